// ===== rtl/wbpb_pkg.sv =====
// ----------------------------------------------------------------------------
// wbpb_pkg
// Shared types and constants for the write-back page buffer.
// ----------------------------------------------------------------------------
package wbpb_pkg;

	localparam int ADDR_W      = 14;
	localparam int DATA_W      = 8;
	localparam int OFS_W       = 8;
	localparam int PAGE_W      = ADDR_W - OFS_W;
	localparam int PAGE_BYTES  = 1 << OFS_W;
	localparam int FLASH_PAGES = 1 << PAGE_W;
	localparam int SWEEP_W     = OFS_W + 1;
	localparam int TICK_W      = 14;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [TICK_W-1:0] TICK_LIMIT  = 14'd10000;
	localparam logic [TICK_W-1:0] FLUSH_RESET = 14'd500;
	localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

	typedef enum logic [1:0] {
		OP_READ    = 2'd0,
		OP_WRITE   = 2'd1,
		OP_TICK    = 2'd2,
		OP_SERVICE = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t             op;
		logic [ADDR_W-1:0]   address;
		logic [DATA_W-1:0]   wbyte;
		logic                last;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WB,
		ST_LOAD,
		ST_ACC_RD,
		ST_ACC_EX
	} back_state_t;

endpackage

// ===== rtl/wbpb_front.sv =====
// ----------------------------------------------------------------------------
// wbpb_front
// Accepts requests and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module wbpb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wbpb_pkg::cmd_t      push_cmd,
	output logic                full,
	output wbpb_pkg::queue_head_t head,
	input  logic                pop
);
	import wbpb_pkg::*;

	cmd_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign do_push    = push && !full;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/wbpb_back.sv =====
// ----------------------------------------------------------------------------
// wbpb_back
// Executes queued requests against the page buffer and the flash store.
// ----------------------------------------------------------------------------
module wbpb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wbpb_pkg::queue_head_t       head,
	output logic                        pop,
	input  logic [wbpb_pkg::TICK_W-1:0] flush_ticks,
	output logic                        res_valid,
	output logic [wbpb_pkg::DATA_W-1:0] res_byte,
	output logic                        res_written,
	output logic                        res_loaded,
	output logic                        res_dirty,
	output logic                        res_done
);
	import wbpb_pkg::*;

	back_state_t        state_q, state_d;
	cmd_t               cmd_q;
	logic [PAGE_W-1:0]  bp_q;
	logic               dirty_q;
	logic [TICK_W-1:0]  ticks_q;
	logic               pend_q;
	logic               wb_flag_q;
	logic               ld_flag_q;
	logic [SWEEP_W-1:0] sweep_q;
	logic               wr_s1;
	logic [OFS_W-1:0]   wr_addr_s1;

	logic [DATA_W-1:0]  buf_mem [PAGE_BYTES];
	logic [PAGE_BYTES-1:0] buf_vld_q;
	logic [DATA_W-1:0]  buf_rdata_s1;
	logic               buf_rvld_s1;
	logic [DATA_W-1:0]  flash_mem [PAGE_BYTES*FLASH_PAGES];
	logic [FLASH_PAGES-1:0] flash_pw_q;
	logic [DATA_W-1:0]  flash_rdata_s1;
	logic               flash_rvld_s1;

	logic [PAGE_W-1:0]  page;
	logic [OFS_W-1:0]   ofs;
	logic               hit;
	logic               sweeping;
	logic               sweep_done;
	logic               buf_re;
	logic [OFS_W-1:0]   buf_raddr;
	logic               buf_we;
	logic [OFS_W-1:0]   buf_waddr;
	logic [DATA_W-1:0]  buf_wdata;
	logic               flash_re;
	logic               flash_we;
	logic [DATA_W-1:0]  acc_byte;
	logic               changed;
	logic [TICK_W-1:0]  t_inc;
	logic [TICK_W-1:0]  t_sat;
	logic               t_fire;
	logic               emit;
	logic [DATA_W-1:0]  e_byte;
	logic               e_written;
	logic               e_dirty;
	logic               e_done;

	assign page       = cmd_q.address[ADDR_W-1:OFS_W];
	assign ofs        = cmd_q.address[OFS_W-1:0];
	assign hit        = (page == bp_q);
	assign sweeping   = !sweep_q[OFS_W];
	assign sweep_done = sweep_q[OFS_W] && !wr_s1;
	assign acc_byte   = buf_rvld_s1 ? buf_rdata_s1 : ERASED_BYTE;
	assign changed    = (acc_byte != cmd_q.wbyte);
	assign t_inc      = dirty_q ? ticks_q + TICK_W'(1) : ticks_q;
	assign t_sat      = (t_inc > TICK_LIMIT) ? TICK_LIMIT : t_inc;
	assign t_fire     = (t_sat > flush_ticks);

	assign buf_re    = ((state_q == ST_WB) && sweeping) || (state_q == ST_ACC_RD);
	assign buf_raddr = (state_q == ST_WB) ? sweep_q[OFS_W-1:0] : ofs;
	assign flash_re  = (state_q == ST_LOAD) && sweeping;
	assign flash_we  = wr_s1 && (state_q == ST_WB);

	always_comb begin
		buf_we    = 1'b0;
		buf_waddr = wr_addr_s1;
		buf_wdata = flash_rvld_s1 ? flash_rdata_s1 : ERASED_BYTE;
		if (wr_s1 && (state_q == ST_LOAD)) begin
			buf_we = 1'b1;
		end else if ((state_q == ST_ACC_EX) && (cmd_q.op == OP_WRITE) && changed) begin
			buf_we    = 1'b1;
			buf_waddr = ofs;
			buf_wdata = cmd_q.wbyte;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		emit      = 1'b0;
		e_byte    = '0;
		e_written = wb_flag_q;
		e_dirty   = dirty_q;
		e_done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop     = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (cmd_q.op)
					OP_READ, OP_WRITE: begin
						if (hit) begin
							state_d = ST_ACC_RD;
						end else if (dirty_q) begin
							state_d = ST_WB;
						end else begin
							state_d = ST_LOAD;
						end
					end
					OP_TICK: begin
						emit    = 1'b1;
						state_d = ST_IDLE;
					end
					default: begin
						if (pend_q) begin
							state_d = ST_WB;
						end else begin
							emit    = 1'b1;
							state_d = ST_IDLE;
						end
					end
				endcase
			end
			ST_WB: begin
				if (sweep_done) begin
					if (cmd_q.op == OP_SERVICE) begin
						emit      = 1'b1;
						e_written = 1'b1;
						e_dirty   = 1'b0;
						state_d   = ST_IDLE;
					end else begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				if (sweep_done) begin
					state_d = ST_ACC_RD;
				end
			end
			ST_ACC_RD: begin
				state_d = ST_ACC_EX;
			end
			ST_ACC_EX: begin
				emit    = 1'b1;
				e_done  = cmd_q.last;
				e_byte  = (cmd_q.op == OP_READ) ? acc_byte : '0;
				e_dirty = dirty_q || ((cmd_q.op == OP_WRITE) && changed);
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (buf_re) begin
			buf_rdata_s1 <= buf_mem[buf_raddr];
		end
		if (buf_we) begin
			buf_mem[buf_waddr] <= buf_wdata;
		end
		if (flash_re) begin
			flash_rdata_s1 <= flash_mem[{page, sweep_q[OFS_W-1:0]}];
		end
		if (flash_we) begin
			flash_mem[{bp_q, wr_addr_s1}] <= buf_rvld_s1 ? buf_rdata_s1 : ERASED_BYTE;
		end
		if (pop) begin
			cmd_q <= head.cmd;
		end
		wr_addr_s1 <= sweep_q[OFS_W-1:0];
		res_byte   <= e_byte;
		res_loaded <= ld_flag_q;
		res_done   <= e_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			bp_q          <= '0;
			dirty_q       <= 1'b0;
			ticks_q       <= '0;
			pend_q        <= 1'b0;
			wb_flag_q     <= 1'b0;
			ld_flag_q     <= 1'b0;
			sweep_q       <= '0;
			wr_s1         <= 1'b0;
			buf_vld_q     <= '0;
			buf_rvld_s1   <= 1'b0;
			flash_pw_q    <= '0;
			flash_rvld_s1 <= 1'b0;
			res_valid     <= 1'b0;
			res_written   <= 1'b0;
			res_dirty     <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid   <= emit;
			res_written <= e_written;
			res_dirty   <= e_dirty;
			wr_s1       <= ((state_q == ST_WB) || (state_q == ST_LOAD)) && sweeping;
			if (buf_re) begin
				buf_rvld_s1 <= buf_vld_q[buf_raddr];
			end
			if (buf_we) begin
				buf_vld_q[buf_waddr] <= 1'b1;
			end
			if (flash_re) begin
				flash_rvld_s1 <= flash_pw_q[page];
			end
			if (flash_we) begin
				flash_pw_q[bp_q] <= 1'b1;
			end
			if (((state_q == ST_WB) || (state_q == ST_LOAD)) && sweeping) begin
				sweep_q <= sweep_q + SWEEP_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					wb_flag_q <= 1'b0;
					ld_flag_q <= 1'b0;
				end
				ST_DECODE: begin
					sweep_q <= '0;
					if (state_d == ST_WB) begin
						wb_flag_q <= 1'b1;
					end
					if (state_d == ST_LOAD) begin
						ld_flag_q <= 1'b1;
					end
					if (cmd_q.op == OP_TICK) begin
						if (t_fire) begin
							pend_q  <= 1'b1;
							ticks_q <= '0;
						end else begin
							ticks_q <= t_sat;
						end
					end
				end
				ST_WB: begin
					if (sweep_done) begin
						dirty_q <= 1'b0;
						sweep_q <= '0;
						if (cmd_q.op == OP_SERVICE) begin
							pend_q <= 1'b0;
						end else begin
							ld_flag_q <= 1'b1;
						end
					end
				end
				ST_LOAD: begin
					if (sweep_done) begin
						bp_q    <= page;
						dirty_q <= 1'b0;
					end
				end
				ST_ACC_EX: begin
					dirty_q <= e_dirty;
				end
				default: begin
					sweep_q <= sweep_q;
				end
			endcase
		end
	end

endmodule

// ===== rtl/write_back_page_buffer.sv =====
// ----------------------------------------------------------------------------
// write_back_page_buffer
// One-page write-back buffer in front of a byte-addressed flash store.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; up to two requests
// queue ahead of execution. Each request yields one result, shown for one
// cycle with result_valid. A tick, or a service with no flush pending, is
// answered from the decode state; a hit first reads the buffer. A write-back
// or a load sweeps the whole 256-byte page, so a dirty miss sweeps it once
// for the write-back and once for the load. Flash contents read as erased
// until a page is first written back.
module write_back_page_buffer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  opcode,
	input  logic [wbpb_pkg::ADDR_W-1:0] address,
	input  logic [wbpb_pkg::DATA_W-1:0] write_byte,
	input  logic                        burst_last,
	input  logic                        cfg_we,
	input  logic [wbpb_pkg::TICK_W-1:0] cfg_wdata,
	output logic                        result_valid,
	output logic [wbpb_pkg::DATA_W-1:0] read_byte,
	output logic                        page_written_back,
	output logic                        page_loaded,
	output logic                        dirty,
	output logic                        transfer_done
);
	import wbpb_pkg::*;

	logic [TICK_W-1:0] auto_flush_ticks_q;
	cmd_t              push_cmd;
	queue_head_t       head;
	logic              pop;

	assign push_cmd.op      = opcode_t'(opcode);
	assign push_cmd.address = address;
	assign push_cmd.wbyte   = write_byte;
	assign push_cmd.last    = burst_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_flush_ticks_q <= FLUSH_RESET;
		end else if (cfg_we) begin
			auto_flush_ticks_q <= cfg_wdata;
		end
	end

	wbpb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (start),
		.push_cmd (push_cmd),
		.full     (busy),
		.head     (head),
		.pop      (pop)
	);

	wbpb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.flush_ticks (auto_flush_ticks_q),
		.res_valid   (result_valid),
		.res_byte    (read_byte),
		.res_written (page_written_back),
		.res_loaded  (page_loaded),
		.res_dirty   (dirty),
		.res_done    (transfer_done)
	);

endmodule

// ===== rtl/wbpb_checker.sv =====
// ----------------------------------------------------------------------------
// wbpb_checker
// Port-level checks on the write-back page buffer.
// ----------------------------------------------------------------------------
module wbpb_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid,
	input logic page_written_back,
	input logic page_loaded,
	input logic dirty
);

	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("results on consecutive cycles");

	a_flush_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && page_written_back && !page_loaded |-> !dirty)
		else $error("page still dirty after flush");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy raised without a request");

endmodule

bind write_back_page_buffer wbpb_checker u_wbpb_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.start             (start),
	.busy              (busy),
	.result_valid      (result_valid),
	.page_written_back (page_written_back),
	.page_loaded       (page_loaded),
	.dirty             (dirty)
);

// ===== bench/write_back_page_buffer_test.sv =====
// ----------------------------------------------------------------------------
// write_back_page_buffer_test
// Self-checking bench for the one-page write-back flash buffer. A clocked
// driver feeds requests from a queue, predicts each result with its own model
// of the buffer and the flash, and a clocked monitor compares every result
// field by field. Phases run under several flush thresholds, extremes included.
// ----------------------------------------------------------------------------
module write_back_page_buffer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import wbpb_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 700;

	typedef struct {
		opcode_t           op;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] wbyte;
		logic              last;
	} request_t;

	typedef struct {
		logic [DATA_W-1:0] rbyte;
		logic              written;
		logic              loaded;
		logic              dirty;
		logic              done;
	} outcome_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [1:0]          opcode = '0;
	logic [ADDR_W-1:0]   address = '0;
	logic [DATA_W-1:0]   write_byte = '0;
	logic                burst_last = 1'b0;
	logic                cfg_we = 1'b0;
	logic [TICK_W-1:0]   cfg_wdata = '0;
	logic                result_valid;
	logic [DATA_W-1:0]   read_byte;
	logic                page_written_back;
	logic                page_loaded;
	logic                dirty;
	logic                transfer_done;

	write_back_page_buffer DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .address(address), .write_byte(write_byte),
		.burst_last(burst_last), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.result_valid(result_valid), .read_byte(read_byte),
		.page_written_back(page_written_back), .page_loaded(page_loaded),
		.dirty(dirty), .transfer_done(transfer_done)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// buffer model
	logic [DATA_W-1:0] flash_mem [FLASH_PAGES*PAGE_BYTES];
	logic [DATA_W-1:0] page_mem [PAGE_BYTES];
	logic [PAGE_W-1:0] held_page;
	logic              held_dirty;
	int unsigned       tick_count;
	logic              flush_req;
	logic [TICK_W-1:0] flush_ticks;

	request_t pending_requests [$];
	outcome_t expected_results [$];
	request_t cur;
	int       gap_left = 0;
	bit       idle_en = 1'b1;
	int       mismatches = 0;
	int       accepted = 0;
	int       results_seen = 0;
	int       misses = 0;
	int       flushes = 0;
	int       quiet_cycles = 0;

	function automatic outcome_t buffer_step(request_t r);
		outcome_t o;
		logic [PAGE_W-1:0] pg;
		logic [OFS_W-1:0]  ofs;
		o = '{default: '0};
		pg = r.address[ADDR_W-1:OFS_W];
		ofs = r.address[OFS_W-1:0];
		if (r.op == OP_READ || r.op == OP_WRITE) begin
			if (pg != held_page) begin
				if (held_dirty) begin
					for (int i = 0; i < PAGE_BYTES; i++)
						flash_mem[held_page*PAGE_BYTES+i] = page_mem[i];
					o.written = 1'b1;
				end
				for (int i = 0; i < PAGE_BYTES; i++)
					page_mem[i] = flash_mem[pg*PAGE_BYTES+i];
				held_page = pg;
				held_dirty = 1'b0;
				o.loaded = 1'b1;
				misses++;
			end
			if (r.op == OP_READ) begin
				o.rbyte = page_mem[ofs];
			end else if (page_mem[ofs] != r.wbyte) begin
				page_mem[ofs] = r.wbyte;
				held_dirty = 1'b1;
			end
			o.done = r.last;
		end else if (r.op == OP_TICK) begin
			if (held_dirty)
				tick_count++;
			if (tick_count > TICK_LIMIT)
				tick_count = TICK_LIMIT;
			if (tick_count > flush_ticks) begin
				flush_req = 1'b1;
				tick_count = 0;
			end
		end else if (flush_req) begin
			for (int i = 0; i < PAGE_BYTES; i++)
				flash_mem[held_page*PAGE_BYTES+i] = page_mem[i];
			held_dirty = 1'b0;
			flush_req = 1'b0;
			o.written = 1'b1;
			flushes++;
		end
		o.dirty = held_dirty;
		return o;
	endfunction

	always @(posedge clk) begin
		if (start && !busy) begin
			expected_results.push_back(buffer_step(cur));
			accepted++;
		end
		if (start && busy) begin
			start <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (pending_requests.size() > 0 && idle_en && $urandom_range(9) == 0) begin
			gap_left <= $urandom_range(10);
			start <= 1'b0;
		end else if (pending_requests.size() > 0) begin
			cur = pending_requests.pop_front();
			opcode <= cur.op;
			address <= cur.address;
			write_byte <= cur.wbyte;
			burst_last <= cur.last;
			start <= 1'b1;
		end else begin
			start <= 1'b0;
		end
	end

	always @(posedge clk) begin
		outcome_t e;
		if (result_valid) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: read_byte %h flags %b%b%b%b", read_byte,
						page_written_back, page_loaded, dirty, transfer_done);
			end else begin
				e = expected_results.pop_front();
				if (read_byte !== e.rbyte || page_written_back !== e.written ||
						page_loaded !== e.loaded || dirty !== e.dirty ||
						transfer_done !== e.done) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h %b%b%b%b, got %h %b%b%b%b",
							e.rbyte, e.written, e.loaded, e.dirty, e.done, read_byte,
							page_written_back, page_loaded, dirty, transfer_done);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("write_back_page_buffer_test: errors");
			$finish;
		end
	end

	task automatic add_request(opcode_t op, int unsigned addr, int unsigned wb, bit last);
		request_t r;
		r.op = op;
		r.address = addr[ADDR_W-1:0];
		r.wbyte = wb[DATA_W-1:0];
		r.last = last;
		pending_requests.push_back(r);
	endtask

	task automatic drain();
		wait (pending_requests.size() == 0 && !start && expected_results.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_flush_ticks(int unsigned v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[TICK_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		flush_ticks = v[TICK_W-1:0];
	endtask

	task automatic random_mix(int n, int tick_pct);
		int unsigned hot_a;
		int unsigned hot_b;
		int unsigned pg;
		int unsigned addr;
		int unsigned pick;
		hot_a = $urandom_range(FLASH_PAGES-1);
		hot_b = $urandom_range(FLASH_PAGES-1);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			pg = ($urandom_range(9) < 7) ? hot_a : hot_b;
			addr = pg * PAGE_BYTES + $urandom_range(PAGE_BYTES-1);
			if ($urandom_range(19) == 0)
				addr = $urandom_range((1 << ADDR_W) - 1);
			if (pick < tick_pct)
				add_request(OP_TICK, $urandom, $urandom, $urandom_range(1));
			else if (pick < tick_pct + 8)
				add_request(OP_SERVICE, $urandom, $urandom, $urandom_range(1));
			else if (pick < 60)
				add_request(OP_WRITE, addr, $urandom_range(255), $urandom_range(1));
			else
				add_request(OP_READ, addr, $urandom_range(255), $urandom_range(1));
		end
	endtask

	initial begin
		for (int i = 0; i < FLASH_PAGES*PAGE_BYTES; i++)
			flash_mem[i] = ERASED_BYTE;
		for (int i = 0; i < PAGE_BYTES; i++)
			page_mem[i] = ERASED_BYTE;
		held_page = '0;
		held_dirty = 1'b0;
		tick_count = 0;
		flush_req = 1'b0;
		flush_ticks = FLUSH_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_request(OP_READ, 0, 8'h00, 1'b0);
		add_request(OP_WRITE, 0, 8'hFF, 1'b1);
		add_request(OP_SERVICE, 0, 0, 1'b1);
		add_request(OP_TICK, 0, 0, 1'b1);
		add_request(OP_WRITE, 0, 8'h00, 1'b0);
		add_request(OP_WRITE, 255, 8'hA5, 1'b1);
		add_request(OP_TICK, 0, 0, 1'b0);
		add_request(OP_READ, 255, 0, 1'b1);
		add_request(OP_READ, 16383, 0, 1'b1);
		add_request(OP_READ, 16383, 0, 1'b0);
		add_request(OP_READ, 0, 0, 1'b1);
		add_request(OP_READ, 255, 0, 1'b0);
		add_request(OP_WRITE, 14'h2AAA, 8'h55, 1'b1);
		add_request(OP_READ, 14'h1555, 0, 1'b1);
		add_request(OP_READ, 14'h2AAA, 0, 1'b1);
		drain();

		set_flush_ticks(0);
		add_request(OP_WRITE, 14'h0100, 8'h12, 1'b0);
		add_request(OP_TICK, 0, 0, 1'b0);
		add_request(OP_SERVICE, 0, 0, 1'b0);
		add_request(OP_TICK, 0, 0, 1'b0);
		add_request(OP_SERVICE, 0, 0, 1'b1);
		add_request(OP_READ, 14'h0100, 0, 1'b1);
		random_mix(100, 30);
		drain();

		set_flush_ticks(500);
		add_request(OP_WRITE, 14'h0205, 8'h3C, 1'b1);
		for (int i = 0; i < 505; i++)
			add_request(OP_TICK, 0, 0, 1'b0);
		add_request(OP_SERVICE, 0, 0, 1'b0);
		drain();

		set_flush_ticks(16383);
		random_mix(100, 30);
		drain();

		set_flush_ticks(10000);
		random_mix(100, 30);
		drain();

		set_flush_ticks(1);
		random_mix(120, 35);
		drain();

		set_flush_ticks($urandom_range(2, 12));
		random_mix(120, 40);
		drain();

		idle_en = 1'b0;
		set_flush_ticks(3);
		random_mix(100, 35);
		drain();

		$display("run covered %0d requests, %0d results, %0d page misses, %0d serviced flushes",
			accepted, results_seen, misses, flushes);
		$display("flush thresholds 0, 1, 3, 500, 10000, 16383 and one random value");
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("write_back_page_buffer_test: clean");
		end else begin
			$display("write_back_page_buffer_test: errors");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/wbpb_pkg.sv
rtl/wbpb_front.sv
rtl/wbpb_back.sv
rtl/write_back_page_buffer.sv
rtl/wbpb_checker.sv
bench/write_back_page_buffer_test.sv
